[src/bsbe_pkg.sv]
// ----------------------------------------------------------------------------
// bsbe_pkg
// Shared types and codes for the bus slave bit engine: operation codes,
// bus modes, interval codes, the engine state and the input and result beats.
// ----------------------------------------------------------------------------
package bsbe_pkg;

  localparam int unsigned ByteW = 8;

  // event codes carried by an input beat
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_QUEUE = 2'd2;

  // bus modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ADDR  = 3'd1;
  localparam logic [2:0] MODE_RX    = 3'd2;
  localparam logic [2:0] MODE_TX    = 3'd3;
  localparam logic [2:0] MODE_OTHER = 3'd4;

  // next timer interval
  localparam logic [1:0] IV_BIT     = 2'd0;
  localparam logic [1:0] IV_TIMEOUT = 2'd1;
  localparam logic [1:0] IV_OFFSET  = 2'd2;

  // bit positions within a frame
  localparam logic [3:0] BIT_START = 4'd0;
  localparam logic [3:0] BIT_STOP  = 4'd9;
  localparam logic [3:0] BIT_TAIL  = 4'd10;

  // a received bit enters at the top of the shifter
  localparam logic [ByteW-1:0] MSB_IN = 8'h80;

  localparam logic [ByteW-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]       mode;
    logic [3:0]       bit_index;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] data_shift;
    logic [ByteW-1:0] addr_shift;
    logic [ByteW-1:0] reply_len;
    logic [ByteW-1:0] pending_replies;
    logic             timer_running;
    logic             capture_enabled;
    logic [1:0]       interval_choice;
    logic             line_level;
    logic             driving;
  } bsbe_state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             rx_level;
    logic [ByteW-1:0] tx_byte;
    logic [ByteW-1:0] tx_msg_len;
  } bsbe_item_t;

  typedef struct packed {
    logic             line_out;
    logic             drive_tx;
    logic             timer_on;
    logic             edge_armed;
    logic [1:0]       next_interval;
    logic             got_byte_valid;
    logic [ByteW-1:0] got_byte;
    logic             byte_taken;
    logic [2:0]       bus_mode;
  } bsbe_result_t;

endpackage

[src/bsbe_if.sv]
// ----------------------------------------------------------------------------
// bsbe_if
// Valid/ready channels of the bus slave bit engine: the event beat going in
// and the result beat coming out.
// ----------------------------------------------------------------------------
interface bsbe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       rx_level;
  logic [7:0] tx_byte;
  logic [7:0] tx_msg_len;

  modport source (output valid, output op, output rx_level, output tx_byte,
                  output tx_msg_len, input ready);
  modport sink (input valid, input op, input rx_level, input tx_byte,
                input tx_msg_len, output ready);
endinterface

interface bsbe_out_if;
  logic       valid;
  logic       ready;
  logic       line_out;
  logic       drive_tx;
  logic       timer_on;
  logic       edge_armed;
  logic [1:0] next_interval;
  logic       got_byte_valid;
  logic [7:0] got_byte;
  logic       byte_taken;
  logic [2:0] bus_mode;

  modport source (output valid, output line_out, output drive_tx, output timer_on,
                  output edge_armed, output next_interval, output got_byte_valid,
                  output got_byte, output byte_taken, output bus_mode, input ready);
  modport sink (input valid, input line_out, input drive_tx, input timer_on,
                input edge_armed, input next_interval, input got_byte_valid,
                input got_byte, input byte_taken, input bus_mode, output ready);
endinterface

[src/bus_slave_bit_engine.sv]
// ----------------------------------------------------------------------------
// bus_slave_bit_engine
// Slave bit engine for a single-wire half-duplex bit-timed bus.
// ----------------------------------------------------------------------------
// One event beat (bit tick, edge capture or reply-queued notice) is taken
// every clock cycle; its result beat shows on the output channel from the
// result buffer. All of an event's work is one pass of the next-state
// logic in bsbe_step between the engine state register and the result
// register. A two-entry result buffer lets the input keep taking beats while
// one result waits; the input stalls only once both entries are full.
// device_id and broadcast_id are written through the plain write port, by
// the user only while no beat is in flight; the block does not enforce it.
module bus_slave_bit_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_wdata_i,
  bsbe_in_if.sink         in_i,
  bsbe_out_if.source      out_o
);
  import bsbe_pkg::*;

  localparam logic CFG_DEVICE_ID    = 1'b0;
  localparam logic CFG_BROADCAST_ID = 1'b1;

  bsbe_state_t  state_q;
  bsbe_state_t  state_d;
  bsbe_item_t   item;
  bsbe_result_t result;
  bsbe_result_t out_data;
  logic [7:0]   device_id_q;
  logic [7:0]   broadcast_id_q;
  logic         in_accept;
  logic         buf_space;

  assign in_i.ready = buf_space;
  assign in_accept  = in_i.valid & buf_space;

  assign item.op         = in_i.op;
  assign item.rx_level   = in_i.rx_level;
  assign item.tx_byte    = in_i.tx_byte;
  assign item.tx_msg_len = in_i.tx_msg_len;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q    <= 8'h00;
      broadcast_id_q <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_ID:    device_id_q    <= cfg_wdata_i;
        CFG_BROADCAST_ID: broadcast_id_q <= cfg_wdata_i;
        default:          device_id_q    <= device_id_q;
      endcase
    end
  end

  // next-state logic
  bsbe_step u_step (
    .state_i        (state_q),
    .item_i         (item),
    .device_id_i    (device_id_q),
    .broadcast_id_i (broadcast_id_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= MODE_IDLE;
      state_q.bit_index       <= '0;
      state_q.byte_index      <= '0;
      state_q.data_shift      <= '0;
      state_q.addr_shift      <= '0;
      state_q.reply_len       <= '0;
      state_q.pending_replies <= '0;
      state_q.timer_running   <= 1'b0;
      state_q.capture_enabled <= 1'b1;
      state_q.interval_choice <= IV_BIT;
      state_q.line_level      <= 1'b1;
      state_q.driving         <= 1'b0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // result buffer
  bsbe_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (result),
    .space_o (buf_space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_data)
  );

  assign out_o.line_out       = out_data.line_out;
  assign out_o.drive_tx       = out_data.drive_tx;
  assign out_o.timer_on       = out_data.timer_on;
  assign out_o.edge_armed     = out_data.edge_armed;
  assign out_o.next_interval  = out_data.next_interval;
  assign out_o.got_byte_valid = out_data.got_byte_valid;
  assign out_o.got_byte       = out_data.got_byte;
  assign out_o.byte_taken     = out_data.byte_taken;
  assign out_o.bus_mode       = out_data.bus_mode;

endmodule

[src/bsbe_step.sv]
// ----------------------------------------------------------------------------
// bsbe_step
// Next-state logic of the bit engine: takes the current state and one event
// beat and gives the state after the event and the result beat.
// ----------------------------------------------------------------------------
module bsbe_step (
  input  bsbe_pkg::bsbe_state_t  state_i,
  input  bsbe_pkg::bsbe_item_t   item_i,
  input  logic [7:0]             device_id_i,
  input  logic [7:0]             broadcast_id_i,
  output bsbe_pkg::bsbe_state_t  state_o,
  output bsbe_pkg::bsbe_result_t result_o
);
  import bsbe_pkg::*;

  bsbe_state_t     nxt;
  logic            gvalid;
  logic [ByteW-1:0] gbyte;
  logic            taken;
  logic [3:0]      bi;
  logic [3:0]      bi_inc;
  logic [3:0]      bi_dec;
  logic [ByteW-1:0] byte_inc;
  logic            rx;
  logic [ByteW-1:0] rx_msb;
  logic            addr_mine;

  assign bi       = state_i.bit_index;
  assign bi_inc   = bi + 4'd1;
  assign bi_dec   = bi - 4'd1;
  assign byte_inc = state_i.byte_index + 8'd1;
  assign rx       = item_i.rx_level;
  assign rx_msb   = rx ? MSB_IN : '0;
  assign addr_mine = (state_i.addr_shift == device_id_i) ||
                     (state_i.addr_shift == broadcast_id_i);

  // event handling
  always_comb begin
    nxt    = state_i;
    gvalid = 1'b0;
    gbyte  = '0;
    taken  = 1'b0;
    case (item_i.op)
      OP_TICK: begin
        if (state_i.timer_running) begin
          nxt.interval_choice = IV_BIT;
          case (state_i.mode)
            MODE_RX: begin
              if (bi == BIT_START) begin
                nxt.data_shift = '0;
                nxt.bit_index  = bi_inc;
              end else if (bi < BIT_STOP) begin
                nxt.data_shift = (state_i.data_shift >> 1) | rx_msb;
                nxt.bit_index  = bi_inc;
              end else if (bi == BIT_STOP) begin
                gvalid = 1'b1;
                gbyte  = state_i.data_shift;
                if (rx) begin
                  nxt.capture_enabled = 1'b1;
                  nxt.bit_index       = BIT_TAIL;
                  nxt.interval_choice = IV_TIMEOUT;
                end else begin
                  nxt.capture_enabled = 1'b1;
                  nxt.timer_running   = 1'b0;
                  nxt.mode            = MODE_IDLE;
                end
              end else begin
                nxt.mode      = MODE_IDLE;
                nxt.bit_index = bi_inc;
              end
            end
            MODE_TX: begin
              if (bi == BIT_START) begin
                nxt.line_level = 1'b0;
                nxt.data_shift = item_i.tx_byte;
                taken          = 1'b1;
                nxt.bit_index  = 4'd1;
              end else if (bi < BIT_STOP) begin
                nxt.line_level = state_i.data_shift[bi_dec[2:0]];
                nxt.bit_index  = bi_inc;
              end else if (bi == BIT_STOP) begin
                // high stop bit between bytes, low after the last one
                nxt.byte_index = byte_inc;
                if (byte_inc < state_i.reply_len) begin
                  nxt.line_level = 1'b1;
                  nxt.bit_index  = BIT_START;
                end else begin
                  nxt.line_level = 1'b0;
                  nxt.bit_index  = BIT_TAIL;
                end
              end else begin
                nxt.driving         = 1'b0;
                nxt.line_level      = 1'b1;
                nxt.bit_index       = '0;
                nxt.byte_index      = '0;
                nxt.reply_len       = '0;
                nxt.capture_enabled = 1'b1;
                nxt.timer_running   = 1'b0;
                nxt.mode            = MODE_IDLE;
              end
            end
            MODE_ADDR: begin
              if (bi == BIT_START) begin
                nxt.bit_index = 4'd1;
              end else if (bi < BIT_STOP) begin
                nxt.addr_shift = (state_i.addr_shift >> 1) | rx_msb;
                nxt.bit_index  = bi_inc;
              end else if (bi == BIT_STOP) begin
                // read/write bit: high means the master writes
                if (!addr_mine) begin
                  nxt.byte_index = '0;
                  nxt.mode       = MODE_OTHER;
                  if (rx) begin
                    nxt.bit_index = BIT_START;
                  end else begin
                    nxt.capture_enabled = 1'b1;
                    nxt.bit_index       = BIT_TAIL;
                    nxt.interval_choice = IV_TIMEOUT;
                  end
                end else if (rx) begin
                  nxt.mode       = MODE_RX;
                  nxt.bit_index  = BIT_START;
                  nxt.byte_index = '0;
                end else if (state_i.pending_replies != '0) begin
                  nxt.bit_index       = BIT_TAIL;
                  nxt.pending_replies = state_i.pending_replies - 8'd1;
                end else begin
                  nxt.capture_enabled = 1'b1;
                  nxt.timer_running   = 1'b0;
                  nxt.mode            = MODE_IDLE;
                end
              end else if (bi == BIT_TAIL) begin
                nxt.bit_index  = BIT_START;
                nxt.byte_index = '0;
                nxt.reply_len  = item_i.tx_msg_len;
                nxt.line_level = 1'b1;
                nxt.driving    = 1'b1;
                nxt.mode       = MODE_TX;
              end
            end
            MODE_OTHER: begin
              // follow the frame without keeping the data
              if (bi == BIT_START) begin
                nxt.bit_index = bi_inc;
              end else if (bi < BIT_STOP) begin
                nxt.byte_index = (state_i.byte_index >> 1) | rx_msb;
                nxt.bit_index  = bi_inc;
              end else if (bi == BIT_STOP) begin
                nxt.byte_index = '0;
                if (rx) begin
                  nxt.capture_enabled = 1'b1;
                  nxt.bit_index       = BIT_TAIL;
                  nxt.interval_choice = IV_TIMEOUT;
                end else begin
                  nxt.capture_enabled = 1'b1;
                  nxt.timer_running   = 1'b0;
                  nxt.mode            = MODE_IDLE;
                end
              end else begin
                nxt.timer_running = 1'b0;
                nxt.mode          = MODE_IDLE;
                nxt.bit_index     = bi_inc;
              end
            end
            default: begin
              nxt.line_level      = 1'b1;
              nxt.driving         = 1'b0;
              nxt.capture_enabled = 1'b1;
              nxt.timer_running   = 1'b0;
              nxt.mode            = MODE_IDLE;
            end
          endcase
        end
      end
      OP_EDGE: begin
        if (state_i.capture_enabled) begin
          nxt.capture_enabled = 1'b0;
          nxt.interval_choice = IV_OFFSET;
          nxt.timer_running   = 1'b1;
          nxt.bit_index       = BIT_START;
          if (state_i.mode == MODE_IDLE) begin
            nxt.mode       = MODE_ADDR;
            nxt.byte_index = '0;
          end
        end
      end
      OP_QUEUE: begin
        if (state_i.pending_replies != COUNT_MAX) begin
          nxt.pending_replies = state_i.pending_replies + 8'd1;
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  // result beat reflects the state after the event
  always_comb begin
    result_o.line_out       = nxt.line_level;
    result_o.drive_tx       = nxt.driving;
    result_o.timer_on       = nxt.timer_running;
    result_o.edge_armed     = nxt.capture_enabled;
    result_o.next_interval  = nxt.interval_choice;
    result_o.got_byte_valid = gvalid;
    result_o.got_byte       = gbyte;
    result_o.byte_taken     = taken;
    result_o.bus_mode       = nxt.mode;
  end

  assign state_o = nxt;

endmodule

[src/bsbe_out_buf.sv]
// ----------------------------------------------------------------------------
// bsbe_out_buf
// Two-entry result buffer: an output register with a skid stage behind it,
// so a new beat is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module bsbe_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bsbe_pkg::bsbe_result_t data_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output bsbe_pkg::bsbe_result_t data_o
);
  import bsbe_pkg::*;

  logic         out_valid_q;
  logic         skid_valid_q;
  bsbe_result_t out_data_q;
  bsbe_result_t skid_data_q;
  logic         pop;

  assign pop     = out_valid_q & ready_i;
  assign space_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= data_i;
      end else begin
        out_data_q <= data_i;
      end
    end else if (pop && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end
  end

endmodule

[src/bsbe_checker.sv]
// ----------------------------------------------------------------------------
// bsbe_checker
// Port-level checks on the result channel of the bus slave bit engine,
// bound to the top level.
// ----------------------------------------------------------------------------
module bsbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       drive_tx_i,
  input logic       timer_on_i,
  input logic       edge_armed_i,
  input logic       got_byte_valid_i,
  input logic [7:0] got_byte_i,
  input logic       byte_taken_i,
  input logic [2:0] bus_mode_i
);
  import bsbe_pkg::*;

  // the transceiver drives exactly while a reply is being sent
  a_drive_in_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drive_tx_i == (bus_mode_i == MODE_TX)))
    else $error("drive_tx does not match transmit mode");

  // queue bytes are only taken while driving a reply
  a_taken_in_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && byte_taken_i) |-> (drive_tx_i && !got_byte_valid_i))
    else $error("byte taken outside a reply");

  // a halted timer always leaves edge capture armed
  a_halt_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !timer_on_i) |-> edge_armed_i)
    else $error("timer halted with capture disarmed");

  // no received byte means a zero byte field
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !got_byte_valid_i) |-> (got_byte_i == 8'h00))
    else $error("got_byte set without got_byte_valid");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(bus_mode_i)))
    else $error("result beat dropped while stalled");

endmodule

bind bus_slave_bit_engine bsbe_checker u_bsbe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .drive_tx_i       (out_o.drive_tx),
  .timer_on_i       (out_o.timer_on),
  .edge_armed_i     (out_o.edge_armed),
  .got_byte_valid_i (out_o.got_byte_valid),
  .got_byte_i       (out_o.got_byte),
  .byte_taken_i     (out_o.byte_taken),
  .bus_mode_i       (out_o.bus_mode)
);
